/* src/rau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic package
// Shared types and codes for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_DEN = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_MUL2,
      S_COMB,
      S_GCD_PRE,
      S_GCD_ODD,
      S_GCD_LOOP,
      S_DIV_INIT,
      S_DIV_RUN,
      S_FINISH,
      S_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic comb;
      logic gcd_pre;
      logic gcd_odd;
      logic gcd_loop;
      logic div_init;
      logic div_step;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic early_done;
      logic pre_done;
      logic odd_done;
      logic gcd_done;
      logic div_done;
   } sts_type;

endpackage

/* src/rau_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic channel interfaces
// Valid/ready channels for operands and results.
// ----------------------------------------------------------------------------
interface rau_req_if import rau_pkg::*; ();
   logic               valid;
   logic               ready;
   op_type             operation;
   logic signed [31:0] a_num;
   logic signed [31:0] a_den;
   logic signed [31:0] b_num;
   logic signed [31:0] b_den;
   modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if import rau_pkg::*; ();
   logic               valid;
   logic               ready;
   logic signed [31:0] res_num;
   logic [30:0]        res_den;
   status_type         status;
   modport source (output valid, res_num, res_den, status, input ready);
   modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

/* src/rau_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences multiply, combine, gcd and division phases for one transfer.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (in_valid) state_in = S_MUL1;
         S_MUL1:     state_in = S_MUL2;
         S_MUL2:     state_in = S_COMB;
         S_COMB:     state_in = S_GCD_PRE;
         S_GCD_PRE:  if (sts.early_done) state_in = S_OUT;
                     else if (sts.pre_done) state_in = S_GCD_ODD;
         S_GCD_ODD:  if (sts.odd_done) state_in = S_GCD_LOOP;
         S_GCD_LOOP: if (sts.gcd_done) state_in = S_DIV_INIT;
         S_DIV_INIT: state_in = S_DIV_RUN;
         S_DIV_RUN:  if (sts.div_done) state_in = S_FINISH;
         S_FINISH:   state_in = S_OUT;
         S_OUT:      if (out_ready) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         S_IDLE:     begin in_ready = 1'b1; cmd.load = in_valid; end
         S_MUL1:     cmd.mul1 = 1'b1;
         S_MUL2:     cmd.mul2 = 1'b1;
         S_COMB:     cmd.comb = 1'b1;
         S_GCD_PRE:  cmd.gcd_pre = 1'b1;
         S_GCD_ODD:  cmd.gcd_odd = 1'b1;
         S_GCD_LOOP: cmd.gcd_loop = 1'b1;
         S_DIV_INIT: cmd.div_init = 1'b1;
         S_DIV_RUN:  cmd.div_step = 1'b1;
         S_FINISH:   cmd.finish = 1'b1;
         S_OUT:      out_valid = 1'b1;
         default:    ;
      endcase
   end

   a_one_hot_hs: assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid)) else $error("ready and valid together");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("result dropped");
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> state_ff == S_MUL1) else $error("bad start");

endmodule

/* src/rau_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic datapath
// Multipliers, sign-magnitude combine, binary gcd and restoring divider.
// ----------------------------------------------------------------------------
module rau_dp import rau_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  op_type             operation,
   input  logic signed [31:0] a_num,
   input  logic signed [31:0] a_den,
   input  logic signed [31:0] b_num,
   input  logic signed [31:0] b_den,
   input  cmd_type            cmd,
   output sts_type            sts,
   output logic signed [31:0] res_num,
   output logic [30:0]        res_den,
   output status_type         status
);

   localparam int W   = VALUE_WIDTH;
   localparam int PRW = 2 * VALUE_WIDTH;
   localparam int PW  = 2 * VALUE_WIDTH + 1;
   localparam int CW  = $clog2(PW + 1);

   op_type         op_ff;
   logic [W-1:0]   anm_ff, adm_ff, bnm_ff, bdm_ff;
   logic           ans_ff, ads_ff, bns_ff, bds_ff, zero_ff;
   logic [PW-1:0]  p_ff, q_ff, d_ff;
   logic           pneg_ff, qneg_ff, dneg_ff, nneg_ff;
   logic [PW-1:0]  n_ff, x_ff, y_ff;
   logic [CW-1:0]  k_ff, cnt_ff;
   logic [PW-1:0]  rem_ff, quo_ff, nq_ff;
   logic           second_ff;
   logic           pre_first_ff;
   logic signed [31:0] rn_ff;
   logic [30:0]    rd_ff;
   status_type     st_ff;

   logic signed [W-1:0] an_w, ad_w, bn_w, bd_w;
   assign an_w = a_num[W-1:0];
   assign ad_w = a_den[W-1:0];
   assign bn_w = b_num[W-1:0];
   assign bd_w = b_den[W-1:0];

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
      mag = v[W-1] ? W'(-v) : W'(v);
   endfunction

   // Full-width products of the operand magnitudes.
   logic [W-1:0]   p_rhs_w, d_rhs_w;
   logic [PRW-1:0] p_prod_w, q_prod_w, d_prod_w;
   assign p_rhs_w  = (op_ff == OP_MUL) ? bnm_ff : bdm_ff;
   assign d_rhs_w  = (op_ff == OP_DIV) ? bnm_ff : bdm_ff;
   assign p_prod_w = PRW'(anm_ff) * PRW'(p_rhs_w);
   assign q_prod_w = PRW'(adm_ff) * PRW'(bnm_ff);
   assign d_prod_w = PRW'(adm_ff) * PRW'(d_rhs_w);

   logic [PW-1:0] g_w, div_src, rem_sh, limit_w;
   logic          neg_w;
   assign g_w     = x_ff << k_ff;
   assign div_src = second_ff ? d_ff : n_ff;
   assign rem_sh  = {rem_ff[PW-2:0], quo_ff[PW-1]};
   assign neg_w   = nneg_ff ^ dneg_ff;
   assign limit_w = PW'((64'd1 << (W - 1)) - 64'd1);

   always_ff @(posedge clock) begin
      pre_first_ff <= cmd.comb;
      if (cmd.load) begin
         op_ff  <= operation;
         anm_ff <= mag(an_w); ans_ff <= an_w[W-1];
         adm_ff <= mag(ad_w); ads_ff <= ad_w[W-1];
         bnm_ff <= mag(bn_w); bns_ff <= bn_w[W-1];
         bdm_ff <= mag(bd_w); bds_ff <= bd_w[W-1];
         zero_ff <= (ad_w == '0) || (bd_w == '0) || (operation == OP_DIV && bn_w == '0);
      end
      if (cmd.mul1) begin
         // Numerator-side products.
         p_ff    <= PW'(p_prod_w);
         pneg_ff <= (op_ff == OP_MUL) ? (ans_ff ^ bns_ff) : (ans_ff ^ bds_ff);
         q_ff    <= PW'(q_prod_w);
         qneg_ff <= ads_ff ^ bns_ff ^ (op_ff == OP_SUB);
      end
      if (cmd.mul2) begin
         d_ff    <= PW'(d_prod_w);
         dneg_ff <= (op_ff == OP_DIV) ? (ads_ff ^ bns_ff) : (ads_ff ^ bds_ff);
      end
      if (cmd.comb) begin
         if (op_ff == OP_MUL || op_ff == OP_DIV) begin
            n_ff <= p_ff; nneg_ff <= pneg_ff;
         end else begin
            if ((pneg_ff && p_ff != '0) == (qneg_ff && q_ff != '0) ||
                p_ff == '0 || q_ff == '0) begin
               n_ff    <= p_ff + q_ff;
               nneg_ff <= (p_ff != '0) ? pneg_ff : qneg_ff;
            end else if (p_ff >= q_ff) begin
               n_ff <= p_ff - q_ff; nneg_ff <= pneg_ff;
            end else begin
               n_ff <= q_ff - p_ff; nneg_ff <= qneg_ff;
            end
         end
         k_ff <= '0;
      end
      if (cmd.gcd_pre) begin
         // The first cycle loads the gcd operands; later cycles strip
         // common factors of two.
         if (pre_first_ff) begin
            x_ff <= n_ff; y_ff <= d_ff; k_ff <= '0;
         end else if (!(x_ff[0] | y_ff[0] | zero_ff | (n_ff == '0))) begin
            x_ff <= x_ff >> 1; y_ff <= y_ff >> 1; k_ff <= k_ff + 1'b1;
         end
      end
      if (cmd.gcd_odd && !x_ff[0]) x_ff <= x_ff >> 1;
      if (cmd.gcd_loop && y_ff != '0) begin
         if (!y_ff[0]) y_ff <= y_ff >> 1;
         else if (x_ff > y_ff) begin
            y_ff <= x_ff - y_ff; x_ff <= y_ff;
         end else y_ff <= y_ff - x_ff;
      end
      if (cmd.div_init) begin
         second_ff <= 1'b0;
         rem_ff <= '0; quo_ff <= n_ff; cnt_ff <= CW'(PW);
         x_ff <= g_w;
      end
      if (cmd.div_step) begin
         // One restoring quotient bit per cycle; numerator then denominator.
         if (cnt_ff == '0) begin
            if (!second_ff) begin
               nq_ff <= quo_ff; second_ff <= 1'b1;
               rem_ff <= '0; quo_ff <= d_ff; cnt_ff <= CW'(PW);
            end
         end else if (rem_sh >= x_ff) begin
            rem_ff <= rem_sh - x_ff; quo_ff <= {quo_ff[PW-2:0], 1'b1};
            cnt_ff <= cnt_ff - 1'b1;
         end else begin
            rem_ff <= rem_sh; quo_ff <= {quo_ff[PW-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (cmd.gcd_pre && (zero_ff || n_ff == '0)) begin
         rn_ff <= '0;
         rd_ff <= zero_ff ? 31'd0 : 31'd1;
         st_ff <= zero_ff ? ST_ZERO_DEN : ST_OK;
      end
      if (cmd.finish) begin
         if (quo_ff > limit_w || nq_ff > (neg_w ? limit_w + 1'b1 : limit_w)) begin
            rn_ff <= '0; rd_ff <= '0; st_ff <= ST_OVERFLOW;
         end else begin
            rn_ff <= neg_w ? 32'(-nq_ff) : 32'(nq_ff);
            rd_ff <= 31'(quo_ff);
            st_ff <= ST_OK;
         end
      end
   end

   assign sts.early_done = zero_ff || (n_ff == '0);
   assign sts.pre_done   = !pre_first_ff && (x_ff[0] | y_ff[0]);
   assign sts.odd_done   = x_ff[0];
   assign sts.gcd_done   = (y_ff == '0);
   assign sts.div_done   = second_ff && (cnt_ff == '0);

   assign res_num = rn_ff;
   assign res_den = rd_ff;
   assign status  = st_ff;

endmodule

/* src/rational_arithmetic_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
// The req channel carries an operation code and two fractions. One transfer on
// req yields exactly one transfer on rsp, holding the reduced numerator, the
// positive reduced denominator and a status code.
// The block works on one item at a time. A zero denominator or zero result
// goes straight from the gcd pre-step to rsp. Otherwise the block runs the
// multiply and combine steps, a binary gcd loop over the 65-bit values
// (one shift or subtract per cycle), then a restoring divider that produces
// one quotient bit per cycle, first for the numerator and then for the
// denominator.
// req_ready is high only while the block is idle.
// The result is held on rsp until rsp_ready is high; while the receiver
// stalls no new item is taken. Synchronous reset returns the controller to
// idle; no result is pending afterwards.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);

   cmd_type cmd;
   sts_type sts;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rau_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock     (clock),
      .operation (req.operation),
      .a_num     (req.a_num),
      .a_den     (req.a_den),
      .b_num     (req.b_num),
      .b_den     (req.b_den),
      .cmd       (cmd),
      .sts       (sts),
      .res_num   (rsp.res_num),
      .res_den   (rsp.res_den),
      .status    (rsp.status)
   );

endmodule
